>>> sv/lppr_pkg.sv
// Package for the length-prefixed packet receiver.
// Holds frame constants, result kinds and the controller/datapath interface types.
// No dependencies.
package lppr_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 64;
	localparam int unsigned STORE_DEPTH     = 64;
	localparam int unsigned ADDR_W          = $clog2(STORE_DEPTH);
	localparam int unsigned HDR_BYTES       = 3;
	localparam int unsigned FRAME_OVERHEAD  = 4;
	localparam int unsigned FLEN_W          = 9;
	localparam int unsigned CNT_W           = 7;
	localparam int unsigned TICK_W          = 16;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd100;
	localparam int unsigned OUT_DATA_W      = 40;

	typedef enum logic [1:0] {
		KIND_OK   = 2'd0,
		KIND_LEN  = 2'd1,
		KIND_CSUM = 2'd2
	} kind_t;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		logic  tick;
		logic  byte_seen;
		logic  take_first;
		logic  take_header;
		logic  take_payload;
		logic  drop;
		logic  idx_clr;
		logic  idx_inc;
		logic  rd_en;
		logic  load_single;
		logic  load_payload;
		kind_t kind;
	} lppr_cmd_t;

	typedef struct packed {
		logic byte_is_port;
		logic len_too_big;
		logic more_payload;
		logic xor_match;
		logic len_zero;
		logic timed_out;
		logic emit_last;
		logic out_free;
	} lppr_stat_t;

endpackage

>>> sv/length_prefixed_packet_receiver_core.sv
// Top level of the length-prefixed packet receiver.
// Instantiates lppr_ctrl and lppr_dp; depends on lppr_pkg.
//
// Each input beat is a received byte (s_tuser 0) or a time tick (s_tuser 1). A
// frame is command, port, length, payload and XOR checksum. When the checksum
// byte arrives, a good frame with N payload bytes gives N result beats, each
// made by a payload store read and then an output register load, and input
// stays busy until the last beat is loaded, through any m_tready stall; an
// error or an empty payload gives one beat and holds input until it is loaded.
// The output register lets the next input beat in while the last result still
// waits. Length errors (length + 4 > 64) are reported at the length byte; a
// partial frame seeing more than timeout_ticks ticks without a byte is dropped
// with no result. timeout_ticks resets to 100.
module length_prefixed_packet_receiver_core import lppr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TICK_W-1:0]     cfg_wdata,  // timeout_ticks
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,    // rx_byte
	input  logic                  s_tuser,    // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// command[7:0], port[15:8], payload_length[23:16], payload_index[29:24],
	// payload_byte[37:30], zero[39:38]
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,    // kind
	output logic                  m_tlast     // last
);

	lppr_cmd_t  cmd;
	lppr_stat_t stat;

	lppr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	lppr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx_byte   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// no result load while the output register holds an untaken beat
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_single || cmd.load_payload) |-> stat.out_free)
		else $error("result loaded over a pending beat");

	// only payload runs have non-final beats
	a_nonlast_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == KIND_OK))
		else $error("non-final beat with error kind");

	// payload index stays inside the frame's length
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[23:16] != 8'd0) |-> ({2'b00, m_tdata[29:24]} < m_tdata[23:16]))
		else $error("payload index beyond length");

	// at most one frame update per cycle
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take_first, cmd.take_header, cmd.take_payload, cmd.tick}))
		else $error("conflicting frame updates");

endmodule

>>> sv/lppr_ctrl.sv
// Controller for the packet receiver: frame phase and result sequencing.
// Depends on lppr_pkg; drives lppr_dp through lppr_cmd_t, reads lppr_stat_t.
module lppr_ctrl import lppr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       op,
	input  lppr_stat_t stat,
	output logic       s_tready,
	output lppr_cmd_t  cmd
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		SQ_TAKE,
		SQ_ONE,
		SQ_READ,
		SQ_LOAD
	} seq_t;

	phase_t phase_q, phase_d;
	seq_t   seq_q, seq_d;
	kind_t  pend_kind_q, pend_kind_d;
	logic   accept;

	assign s_tready = (seq_q == SQ_TAKE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd         = '0;
		cmd.kind    = KIND_OK;
		phase_d     = phase_q;
		seq_d       = seq_q;
		pend_kind_d = pend_kind_q;
		unique case (seq_q)
			SQ_TAKE: begin
				if (accept) begin
					if (op == OP_TICK) begin
						cmd.tick = 1'b1;
						if (stat.timed_out && phase_q != PH_IDLE) begin
							cmd.drop = 1'b1;
							phase_d  = PH_IDLE;
						end
					end else begin
						cmd.byte_seen = 1'b1;
						unique case (phase_q)
							PH_IDLE: begin
								cmd.take_first = 1'b1;
								phase_d        = PH_HEADER;
							end
							PH_HEADER: begin
								cmd.take_header = 1'b1;
								if (!stat.byte_is_port) begin
									if (stat.len_too_big) begin
										cmd.drop    = 1'b1;
										phase_d     = PH_IDLE;
										pend_kind_d = KIND_LEN;
										seq_d       = SQ_ONE;
									end else begin
										phase_d = PH_DATA;
									end
								end
							end
							PH_DATA: begin
								if (stat.more_payload) begin
									cmd.take_payload = 1'b1;
								end else begin
									cmd.drop = 1'b1;
									phase_d  = PH_IDLE;
									if (!stat.xor_match) begin
										pend_kind_d = KIND_CSUM;
										seq_d       = SQ_ONE;
									end else if (stat.len_zero) begin
										pend_kind_d = KIND_OK;
										seq_d       = SQ_ONE;
									end else begin
										cmd.idx_clr = 1'b1;
										seq_d       = SQ_READ;
									end
								end
							end
							default: begin
								cmd.drop = 1'b1;
								phase_d  = PH_IDLE;
							end
						endcase
					end
				end
			end
			SQ_ONE: begin
				if (stat.out_free) begin
					cmd.load_single = 1'b1;
					cmd.kind        = pend_kind_q;
					seq_d           = SQ_TAKE;
				end
			end
			SQ_READ: begin
				cmd.rd_en = 1'b1;
				seq_d     = SQ_LOAD;
			end
			SQ_LOAD: begin
				if (stat.out_free) begin
					cmd.load_payload = 1'b1;
					if (stat.emit_last) begin
						seq_d = SQ_TAKE;
					end else begin
						cmd.idx_inc = 1'b1;
						seq_d       = SQ_READ;
					end
				end
			end
			default: seq_d = SQ_TAKE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			seq_q       <= SQ_TAKE;
			pend_kind_q <= KIND_OK;
		end else begin
			phase_q     <= phase_d;
			seq_q       <= seq_d;
			pend_kind_q <= pend_kind_d;
		end
	end

endmodule

>>> sv/lppr_dp.sv
// Datapath for the packet receiver: header registers, XOR, counters,
// payload store and the output register. Depends on lppr_pkg.
module lppr_dp import lppr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TICK_W-1:0]     cfg_wdata,
	input  logic [7:0]            rx_byte,
	input  lppr_cmd_t             cmd,
	output lppr_stat_t            stat,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);

	logic [TICK_W-1:0] timeout_q;
	logic [TICK_W-1:0] idle_ticks_q;
	logic [TICK_W-1:0] idle_next;
	logic [CNT_W-1:0]  byte_count_q;
	logic [FLEN_W-1:0] frame_length_q;
	logic [FLEN_W-1:0] len_plus;
	logic [7:0]        held_command_q;
	logic [7:0]        held_port_q;
	logic [7:0]        held_length_q;
	logic [7:0]        running_xor_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        store_q [STORE_DEPTH];
	logic [7:0]        rd_data_q;

	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [7:0]        out_command_q;
	logic [7:0]        out_port_q;
	logic [7:0]        out_length_q;
	logic [ADDR_W-1:0] out_index_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;

	assign idle_next = (idle_ticks_q == '1) ? idle_ticks_q : idle_ticks_q + 1'b1;
	assign len_plus  = {1'b0, rx_byte} + FLEN_W'(FRAME_OVERHEAD);
	assign wr_addr   = ADDR_W'(byte_count_q - CNT_W'(HDR_BYTES));

	always_comb begin
		stat.byte_is_port = (byte_count_q == CNT_W'(1));
		stat.len_too_big  = (len_plus > FLEN_W'(MAX_FRAME_BYTES));
		stat.more_payload = ({2'b0, byte_count_q} + FLEN_W'(1)) < frame_length_q;
		stat.xor_match    = (rx_byte == running_xor_q);
		stat.len_zero     = (held_length_q == 8'd0);
		stat.timed_out    = (idle_next > timeout_q);
		stat.emit_last    = ({3'b0, idx_q} + FLEN_W'(1)) == {1'b0, held_length_q};
		stat.out_free     = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q      <= TIMEOUT_RST;
			idle_ticks_q   <= '0;
			byte_count_q   <= '0;
			frame_length_q <= '0;
			held_command_q <= '0;
			held_port_q    <= '0;
			held_length_q  <= '0;
			running_xor_q  <= '0;
			idx_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (cmd.tick) begin
				idle_ticks_q <= idle_next;
			end else if (cmd.byte_seen) begin
				idle_ticks_q <= '0;
			end
			if (cmd.take_first) begin
				held_command_q <= rx_byte;
				running_xor_q  <= rx_byte;
				byte_count_q   <= CNT_W'(1);
			end
			if (cmd.take_header) begin
				running_xor_q <= running_xor_q ^ rx_byte;
				if (stat.byte_is_port) begin
					held_port_q  <= rx_byte;
					byte_count_q <= CNT_W'(2);
				end else begin
					held_length_q  <= rx_byte;
					byte_count_q   <= CNT_W'(HDR_BYTES);
					frame_length_q <= len_plus;
				end
			end
			if (cmd.take_payload) begin
				running_xor_q <= running_xor_q ^ rx_byte;
				byte_count_q  <= byte_count_q + 1'b1;
			end
			if (cmd.drop) begin
				byte_count_q   <= '0;
				frame_length_q <= '0;
				running_xor_q  <= '0;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.load_single || cmd.load_payload) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_payload) begin
			store_q[wr_addr] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= store_q[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single || cmd.load_payload) begin
			out_command_q <= held_command_q;
			out_port_q    <= held_port_q;
			out_length_q  <= held_length_q;
			out_last_q    <= cmd.load_single ? 1'b1 : stat.emit_last;
			out_kind_q    <= cmd.load_single ? cmd.kind : KIND_OK;
			out_index_q   <= cmd.load_single ? '0 : idx_q;
			out_byte_q    <= cmd.load_single ? 8'd0 : rd_data_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_byte_q, out_index_q, out_length_q, out_port_q,
		out_command_q};

endmodule

>>> tb/length_prefixed_packet_receiver_core_checker.sv
// Scoreboard for the length-prefixed packet receiver: mirrors the deframer from
// the accepted input and config beats and checks each result beat in order.
// Depends on lppr_pkg.
module lppr_frame_checker import lppr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [TICK_W-1:0]     cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [1:0]            m_tuser,
	input  logic                  m_tlast,
	output int                    errors,
	output int                    pending
);

	typedef enum logic [1:0] {
		RX_IDLE   = 2'd0,
		RX_HEADER = 2'd1,
		RX_DATA   = 2'd2
	} rx_state_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] command;
		logic [7:0] port;
		logic [7:0] length;
		logic [5:0] index;
		logic [7:0] payload;
		logic       last;
	} frame_result_t;

	rx_state_t           rx_state;
	logic [CNT_W-1:0]    byte_cnt;
	logic [FLEN_W-1:0]   frame_len;
	logic [7:0]          cmd_q, port_q, len_q, csum_q;
	logic [7:0]          payload_mem [STORE_DEPTH];
	logic [TICK_W-1:0]   idle_cnt, timeout_q;
	frame_result_t       results_due[$];

	task automatic report_mismatch(string msg);
		$display("%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	task automatic drop_frame();
		rx_state  = RX_IDLE;
		byte_cnt  = '0;
		frame_len = '0;
		csum_q    = '0;
	endtask

	task automatic queue_result(kind_t k, logic [5:0] idx, logic [7:0] b, logic lst);
		frame_result_t r;
		r.kind    = k;
		r.command = cmd_q;
		r.port    = port_q;
		r.length  = len_q;
		r.index   = idx;
		r.payload = b;
		r.last    = lst;
		results_due.push_back(r);
	endtask

	task automatic deframe_beat(op_t op, logic [7:0] b);
		if (op == OP_TICK) begin
			if (idle_cnt != '1)
				idle_cnt++;
			if (idle_cnt > timeout_q && rx_state != RX_IDLE)
				drop_frame();
		end else begin
			idle_cnt = '0;
			case (rx_state)
				RX_IDLE: begin
					cmd_q    = b;
					csum_q   = b;
					byte_cnt = 1;
					rx_state = RX_HEADER;
				end
				RX_HEADER: begin
					csum_q ^= b;
					if (byte_cnt == 1) begin
						port_q   = b;
						byte_cnt = 2;
					end else begin
						len_q     = b;
						byte_cnt  = 3;
						frame_len = FLEN_W'(b) + FLEN_W'(FRAME_OVERHEAD);
						if (frame_len > MAX_FRAME_BYTES) begin
							queue_result(KIND_LEN, '0, '0, 1'b1);
							drop_frame();
						end else begin
							rx_state = RX_DATA;
						end
					end
				end
				RX_DATA: begin
					if (int'(byte_cnt) + 1 < int'(frame_len)) begin
						payload_mem[ADDR_W'(byte_cnt - CNT_W'(HDR_BYTES))] = b;
						csum_q  ^= b;
						byte_cnt = byte_cnt + 1'b1;
					end else begin
						if (b != csum_q)
							queue_result(KIND_CSUM, '0, '0, 1'b1);
						else if (len_q == 0)
							queue_result(KIND_OK, '0, '0, 1'b1);
						else
							for (int i = 0; i < len_q; i++)
								queue_result(KIND_OK, 6'(i), payload_mem[ADDR_W'(i)],
									i + 1 == len_q);
						drop_frame();
					end
				end
				default: drop_frame();
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			timeout_q = TIMEOUT_RST;
			cmd_q     = '0;
			port_q    = '0;
			len_q     = '0;
			idle_cnt  = '0;
			drop_frame();
			results_due.delete();
		end else begin
			// results first: a beat accepted on this edge cannot be answered on it
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("result beat %0h with nothing due", m_tdata));
				end else begin
					want = results_due.pop_front();
					check_field("kind", m_tuser, want.kind);
					check_field("command", m_tdata[7:0], want.command);
					check_field("port", m_tdata[15:8], want.port);
					check_field("payload_length", m_tdata[23:16], want.length);
					check_field("payload_index", m_tdata[29:24], want.index);
					check_field("payload_byte", m_tdata[37:30], want.payload);
					check_field("tdata pad", m_tdata[39:38], 0);
					check_field("last", m_tlast, want.last);
				end
			end
			if (cfg_we)
				timeout_q = cfg_wdata;
			if (s_tvalid && s_tready)
				deframe_beat(op_t'(s_tuser), s_tdata);
		end
		pending = results_due.size();
	end

endmodule

>>> tb/length_prefixed_packet_receiver_core_tb.sv
// Testbench top for length_prefixed_packet_receiver_core: drives frames, ticks
// and timeout settings under several stall patterns; lppr_frame_checker scores.
// Depends on lppr_pkg, the core and the checker.
module length_prefixed_packet_receiver_core_tb import lppr_pkg::*;;

	localparam int STUCK_LIMIT = 4000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [TICK_W-1:0]     cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	int                    errors;
	int                    pending;
	int                    send_idle_pct;
	int                    recv_stall_pct;
	int                    beats_sent;
	int                    stuck_cycles;
	logic [TICK_W-1:0]     timeout_now;

	length_prefixed_packet_receiver_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	lppr_frame_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("length_prefixed_packet_receiver_core: mismatch");
				$finish;
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_beat(op_t op, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_beat(OP_TICK, 8'($urandom));
	endtask

	task automatic send_frame(logic [7:0] cmd, logic [7:0] port, logic [7:0] len,
			int max_gap, bit corrupt);
		logic [7:0] sum;
		logic [7:0] hdr [3];
		logic [7:0] b;
		hdr = '{cmd, port, len};
		sum = cmd ^ port ^ len;
		for (int i = 0; i < 3; i++) begin
			send_beat(OP_BYTE, hdr[i]);
			send_ticks($urandom_range(max_gap));
		end
		if (int'(len) + FRAME_OVERHEAD > MAX_FRAME_BYTES)
			return;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			sum ^= b;
			send_beat(OP_BYTE, b);
			send_ticks($urandom_range(max_gap));
		end
		send_beat(OP_BYTE, corrupt ? sum ^ (8'd1 << $urandom_range(7)) : sum);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic set_timeout(logic [TICK_W-1:0] v);
		hold_until_drained();
		repeat (8) @(negedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= v;
		timeout_now  = v;
		@(negedge clk);
		cfg_we      <= 1'b0;
	endtask

	task automatic run_random(int n_beats);
		int start;
		int pick;
		int gap;
		logic [7:0] len;
		start = beats_sent;
		while (beats_sent - start < n_beats) begin
			pick = $urandom_range(99);
			gap  = ($urandom_range(3) == 0) ? 2 : 0;
			len  = ($urandom_range(19) == 0) ? 8'($urandom_range(7, 60))
				: 8'($urandom_range(6));
			if (pick < 55) begin
				send_frame(8'($urandom), 8'($urandom), len, gap, 1'b0);
			end else if (pick < 67) begin
				send_frame(8'($urandom), 8'($urandom), len, gap, 1'b1);
			end else if (pick < 75) begin
				send_frame(8'($urandom), 8'($urandom), 8'($urandom_range(61, 255)), gap, 1'b0);
			end else if (pick < 83) begin
				// partial frame, followed by enough ticks to time it out when timeout_now <= 40
				repeat ($urandom_range(1, 3)) send_beat(OP_BYTE, 8'($urandom));
				if (timeout_now <= 40)
					send_ticks(int'(timeout_now) + 1 + $urandom_range(2));
				else
					send_ticks($urandom_range(1, 4));
			end else if (pick < 91) begin
				repeat ($urandom_range(1, 4)) send_beat(OP_BYTE, 8'($urandom));
			end else if (pick < 96) begin
				send_ticks($urandom_range(1, 6));
			end else begin
				hold_until_drained();
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		beats_sent     = 0;
		timeout_now    = TIMEOUT_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty payload, short good frame, bad checksum, oversized lengths
		send_frame(8'h00, 8'hFF, 8'd0, 0, 1'b0);
		send_frame(8'hFF, 8'h00, 8'd2, 0, 1'b0);
		send_frame(8'hA5, 8'h5A, 8'd1, 0, 1'b1);
		send_frame(8'h12, 8'h34, 8'd61, 0, 1'b0);
		send_frame(8'h80, 8'h01, 8'hFF, 0, 1'b0);
		send_ticks(2);

		// timeout of one: two ticks drop a partial frame, one does not
		set_timeout(16'd1);
		send_beat(OP_BYTE, 8'h3C);
		send_ticks(2);
		send_frame(8'h7E, 8'h81, 8'd2, 1, 1'b0);
		send_frame(8'($urandom), 8'($urandom), 8'd60, 0, 1'b0);
		run_random(40);

		set_timeout(16'hFFFF);
		send_idle_pct = 88;
		run_random(40);

		set_timeout(16'($urandom_range(2, 30)));
		send_idle_pct  = 0;
		recv_stall_pct = 88;
		run_random(40);

		// zero timeout: any tick drops a partial frame
		set_timeout(16'd0);
		send_idle_pct  = 14;
		recv_stall_pct = 14;
		run_random(40);

		hold_until_drained();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("length_prefixed_packet_receiver_core: match");
		else
			$display("length_prefixed_packet_receiver_core: mismatch");
		$finish;
	end

endmodule
